// ===== rtl/core/lfpc_pkg.sv =====
// Shared widths, codes and types for the line follower PID controller.
package lfpc_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SPEED_W    = 7;
  localparam int GAIN_W     = 16;
  localparam int POWER_W    = 15;
  localparam int PAT_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int ERR_W      = 3;
  localparam int INT_W      = 14;
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BASE_W     = 16;

  localparam int HOLD_TICKS_DEF     = 20;
  localparam int LOST_TICKS_DEF     = 90;
  localparam int INTEGRAL_LIMIT_DEF = 4096;
  localparam int SAMPLE_BITS_DEF    = 12;

  localparam logic [POWER_W-1:0] FULL_POWER = POWER_W'(25600);

  localparam logic [8:0] SPEED_MUL_FULL = 9'd256;
  localparam logic [8:0] SPEED_MUL_MID  = 9'd179;
  localparam logic [8:0] SPEED_MUL_LOW  = 9'd77;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN    = 3'd6;

  localparam logic [SAMPLE_W-1:0] THR_RESET   = 12'd3276;
  localparam logic [SPEED_W-1:0]  SPEED_RESET = 7'd25;
  localparam logic [GAIN_W-1:0]   KP_RESET    = 16'd3840;
  localparam logic [GAIN_W-1:0]   KI_RESET    = 16'd8;
  localparam logic [GAIN_W-1:0]   KD_RESET    = 16'd179;

  localparam logic [STATUS_W-1:0] RUN_IDLE  = 2'd0;
  localparam logic [STATUS_W-1:0] RUN_DRIVE = 2'd1;
  localparam logic [STATUS_W-1:0] RUN_CROSS = 2'd2;
  localparam logic [STATUS_W-1:0] RUN_LOST  = 2'd3;

  localparam logic [PAT_W-1:0] PAT_NONE       = 3'b000;
  localparam logic [PAT_W-1:0] PAT_RIGHT      = 3'b001;
  localparam logic [PAT_W-1:0] PAT_CENTER     = 3'b010;
  localparam logic [PAT_W-1:0] PAT_MID_RIGHT  = 3'b011;
  localparam logic [PAT_W-1:0] PAT_LEFT       = 3'b100;
  localparam logic [PAT_W-1:0] PAT_SPLIT      = 3'b101;
  localparam logic [PAT_W-1:0] PAT_MID_LEFT   = 3'b110;
  localparam logic [PAT_W-1:0] PAT_ALL        = 3'b111;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [INT_W-1:0] integ_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [SPEED_W-1:0] base_speed;
  } pid_cfg_t;

endpackage

// ===== rtl/core/lfpc_pid.sv =====
// PID datapath: base power, integral update and clamped wheel powers.
module lfpc_pid import lfpc_pkg::*; #(
  parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF
) (
  input  pid_cfg_t           cfg,
  input  err_t               err,
  input  err_t               prev_err,
  input  integ_t             integ,
  output integ_t             integ_nxt,
  output logic [POWER_W-1:0] left_drive,
  output logic [POWER_W-1:0] right_drive
);

  localparam int PT_W  = 20;
  localparam int IT_W  = 32;
  localparam int DT_W  = 21;
  localparam int ADJ_W = 34;

  localparam logic signed [INT_W:0] LIM_POS = (INT_W+1)'(INTEGRAL_LIMIT);
  localparam logic signed [INT_W:0] LIM_NEG = -LIM_POS;

  logic [8:0]               speed_mul;
  logic [BASE_W-1:0]        base;
  logic signed [INT_W:0]    integ_sum;
  logic signed [INT_W:0]    integ_sat;
  logic signed [ERR_W:0]    deriv;
  logic signed [PT_W-1:0]   p_term;
  logic signed [IT_W-1:0]   i_term;
  logic signed [DT_W-1:0]   d_term;
  logic signed [ADJ_W-1:0]  adj;
  logic signed [ADJ_W-1:0]  base_ext;
  logic signed [ADJ_W-1:0]  left_raw;
  logic signed [ADJ_W-1:0]  right_raw;

  function automatic logic [POWER_W-1:0] clamp_power(input logic signed [ADJ_W-1:0] v);
    logic [POWER_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({{(ADJ_W-POWER_W){1'b0}}, FULL_POWER})) begin
      res = FULL_POWER;
    end else begin
      res = v[POWER_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    if (err == '0) begin
      speed_mul = SPEED_MUL_FULL;
    end else if (err == err_t'(1) || err == err_t'(-1)) begin
      speed_mul = SPEED_MUL_MID;
    end else begin
      speed_mul = SPEED_MUL_LOW;
    end
  end

  assign base = BASE_W'(cfg.base_speed) * BASE_W'(speed_mul);

  assign integ_sum = {integ[INT_W-1], integ} + {{(INT_W+1-ERR_W){err[ERR_W-1]}}, err};

  always_comb begin
    if (integ_sum > LIM_POS) begin
      integ_sat = LIM_POS;
    end else if (integ_sum < LIM_NEG) begin
      integ_sat = LIM_NEG;
    end else begin
      integ_sat = integ_sum;
    end
  end

  assign integ_nxt = (err == '0) ? '0 : integ_sat[INT_W-1:0];

  assign deriv = {err[ERR_W-1], err} - {prev_err[ERR_W-1], prev_err};

  assign p_term = PT_W'($signed({1'b0, cfg.kp})) * PT_W'(err);
  assign i_term = IT_W'($signed({1'b0, cfg.ki})) * IT_W'(integ_nxt);
  assign d_term = DT_W'($signed({1'b0, cfg.kd})) * DT_W'(deriv);

  assign adj = ADJ_W'(p_term) + ADJ_W'(i_term) + ADJ_W'(d_term);
  assign base_ext = $signed({{(ADJ_W-BASE_W){1'b0}}, base});

  assign left_raw  = base_ext - adj;
  assign right_raw = base_ext + adj;

  assign left_drive  = clamp_power(left_raw);
  assign right_drive = clamp_power(right_raw);

endmodule

// ===== rtl/core/line_follower_pid_controller_unit.sv =====
// Top level of the three-sensor PID line follower controller.
// Pipeline: an input register, then a result register; a stalled output holds both.
// Throughput: one transaction per cycle while out_ready drains the result register.
// Reset: synchronous active-low rst_n clears the run state to idle, errors and counts to zero,
// and loads the configuration registers with their default values.
module line_follower_pid_controller_unit import lfpc_pkg::*; #(
  parameter int HOLD_TICKS     = HOLD_TICKS_DEF,
  parameter int LOST_TICKS     = LOST_TICKS_DEF,
  parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  input  logic [SAMPLE_W-1:0]   in_left_sample,
  input  logic [SAMPLE_W-1:0]   in_middle_sample,
  input  logic [SAMPLE_W-1:0]   in_right_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POWER_W-1:0]    out_left_drive,
  output logic [POWER_W-1:0]    out_right_drive,
  output logic [PAT_W-1:0]      out_line_pattern,
  output logic [STATUS_W-1:0]   out_run_status
);

  localparam int CMP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [TICK_W-1:0] HOLD_LIM = TICK_W'(HOLD_TICKS);
  localparam logic [TICK_W-1:0] LOST_LIM = TICK_W'(LOST_TICKS);
  localparam integ_t INT_LIM = INT_W'(INTEGRAL_LIMIT);

  logic [SAMPLE_W-1:0] left_thr_r, middle_thr_r, right_thr_r;
  logic [SPEED_W-1:0]  base_speed_r;
  logic [GAIN_W-1:0]   kp_r, ki_r, kd_r;
  pid_cfg_t            pid_cfg;

  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_restart_r;
  logic [SAMPLE_W-1:0] s1_left_r, s1_middle_r, s1_right_r;
  logic                s1_adv;

  err_t                cur_err_r, cur_err_nxt;
  err_t                prev_err_r, prev_err_nxt;
  integ_t              integ_r, integ_nxt;
  logic                all_act_r, all_act_nxt;
  logic [TICK_W-1:0]   all_ticks_r, all_ticks_nxt;
  logic                lost_act_r, lost_act_nxt;
  logic [TICK_W-1:0]   lost_ticks_r, lost_ticks_nxt;
  logic [STATUS_W-1:0] phase_r, phase_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [POWER_W-1:0]  out_left_r, out_left_nxt;
  logic [POWER_W-1:0]  out_right_r, out_right_nxt;
  logic [PAT_W-1:0]    out_pat_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [PAT_W-1:0]    pat;
  err_t                eff_err, eff_prev, err_sel;
  integ_t              eff_integ, pid_integ;
  logic                eff_all_act, eff_lost_act;
  logic [TICK_W-1:0]   eff_all_ticks, eff_lost_ticks, tick_inc;
  logic [STATUS_W-1:0] eff_phase;
  logic                stopped;
  logic [POWER_W-1:0]  pid_left, pid_right;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_thr_r   <= THR_RESET;
      middle_thr_r <= THR_RESET;
      right_thr_r  <= THR_RESET;
      base_speed_r <= SPEED_RESET;
      kp_r         <= KP_RESET;
      ki_r         <= KI_RESET;
      kd_r         <= KD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_THR:   left_thr_r   <= cfg_wdata[SAMPLE_W-1:0];
        REG_MIDDLE_THR: middle_thr_r <= cfg_wdata[SAMPLE_W-1:0];
        REG_RIGHT_THR:  right_thr_r  <= cfg_wdata[SAMPLE_W-1:0];
        REG_BASE_SPEED: base_speed_r <= cfg_wdata[SPEED_W-1:0];
        REG_KP_GAIN:    kp_r         <= cfg_wdata[GAIN_W-1:0];
        REG_KI_GAIN:    ki_r         <= cfg_wdata[GAIN_W-1:0];
        REG_KD_GAIN:    kd_r         <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pid_cfg = '{kp: kp_r, ki: ki_r, kd: kd_r, base_speed: base_speed_r};

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready     = !s1_valid_r || s1_adv;
  assign s1_valid_nxt = (in_valid && in_ready) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_restart_r <= in_restart;
      s1_left_r    <= in_left_sample;
      s1_middle_r  <= in_middle_sample;
      s1_right_r   <= in_right_sample;
    end
  end

  assign pat[2] = s1_left_r[CMP_BITS-1:0]   > left_thr_r[CMP_BITS-1:0];
  assign pat[1] = s1_middle_r[CMP_BITS-1:0] > middle_thr_r[CMP_BITS-1:0];
  assign pat[0] = s1_right_r[CMP_BITS-1:0]  > right_thr_r[CMP_BITS-1:0];

  assign eff_phase      = s1_restart_r ? RUN_DRIVE : phase_r;
  assign eff_err        = s1_restart_r ? err_t'(0) : cur_err_r;
  assign eff_prev       = s1_restart_r ? err_t'(0) : prev_err_r;
  assign eff_integ      = s1_restart_r ? integ_t'(0) : integ_r;
  assign eff_all_act    = s1_restart_r ? 1'b0 : all_act_r;
  assign eff_all_ticks  = s1_restart_r ? '0 : all_ticks_r;
  assign eff_lost_act   = s1_restart_r ? 1'b0 : lost_act_r;
  assign eff_lost_ticks = s1_restart_r ? '0 : lost_ticks_r;

  always_comb begin
    unique case (pat)
      PAT_CENTER:    err_sel = err_t'(0);
      PAT_SPLIT:     err_sel = err_t'(0);
      PAT_MID_LEFT:  err_sel = err_t'(1);
      PAT_LEFT:      err_sel = err_t'(2);
      PAT_MID_RIGHT: err_sel = err_t'(-1);
      PAT_RIGHT:     err_sel = err_t'(-2);
      default:       err_sel = eff_err;
    endcase
  end

  lfpc_pid #(
    .INTEGRAL_LIMIT(INTEGRAL_LIMIT)
  ) u_pid (
    .cfg        (pid_cfg),
    .err        (err_sel),
    .prev_err   (eff_prev),
    .integ      (eff_integ),
    .integ_nxt  (pid_integ),
    .left_drive (pid_left),
    .right_drive(pid_right)
  );

  always_comb begin
    cur_err_nxt    = eff_err;
    prev_err_nxt   = eff_prev;
    integ_nxt      = eff_integ;
    all_act_nxt    = eff_all_act;
    all_ticks_nxt  = eff_all_ticks;
    lost_act_nxt   = eff_lost_act;
    lost_ticks_nxt = eff_lost_ticks;
    phase_nxt      = eff_phase;
    out_left_nxt   = '0;
    out_right_nxt  = '0;
    stopped        = 1'b0;
    tick_inc       = '0;
    if (eff_phase == RUN_DRIVE) begin
      if (pat == PAT_ALL) begin
        if (!eff_all_act) begin
          all_act_nxt   = 1'b1;
          all_ticks_nxt = '0;
        end else begin
          tick_inc      = (eff_all_ticks == '1) ? eff_all_ticks : eff_all_ticks + 1'b1;
          all_ticks_nxt = tick_inc;
          if (tick_inc > HOLD_LIM) begin
            phase_nxt = RUN_CROSS;
            stopped   = 1'b1;
          end
        end
      end else begin
        all_act_nxt = 1'b0;
      end
      if (!stopped) begin
        if (pat == PAT_NONE) begin
          if (!eff_lost_act) begin
            lost_act_nxt   = 1'b1;
            lost_ticks_nxt = '0;
          end else begin
            lost_ticks_nxt = (eff_lost_ticks == '1) ? eff_lost_ticks
                                                   : eff_lost_ticks + 1'b1;
          end
          if (lost_ticks_nxt > LOST_LIM) begin
            phase_nxt = RUN_LOST;
            stopped   = 1'b1;
          end
        end else begin
          lost_act_nxt = 1'b0;
        end
      end
      if (!stopped) begin
        cur_err_nxt   = err_sel;
        prev_err_nxt  = err_sel;
        integ_nxt     = pid_integ;
        out_left_nxt  = pid_left;
        out_right_nxt = pid_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_err_r    <= '0;
      prev_err_r   <= '0;
      integ_r      <= '0;
      all_act_r    <= 1'b0;
      all_ticks_r  <= '0;
      lost_act_r   <= 1'b0;
      lost_ticks_r <= '0;
      phase_r      <= RUN_IDLE;
    end else if (s1_adv) begin
      cur_err_r    <= cur_err_nxt;
      prev_err_r   <= prev_err_nxt;
      integ_r      <= integ_nxt;
      all_act_r    <= all_act_nxt;
      all_ticks_r  <= all_ticks_nxt;
      lost_act_r   <= lost_act_nxt;
      lost_ticks_r <= lost_ticks_nxt;
      phase_r      <= phase_nxt;
    end
  end

  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_left_r   <= out_left_nxt;
      out_right_r  <= out_right_nxt;
      out_pat_r    <= pat;
      out_status_r <= phase_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_drive   = out_left_r;
  assign out_right_drive  = out_right_r;
  assign out_line_pattern = out_pat_r;
  assign out_run_status   = out_status_r;

`ifndef SYNTHESIS
  a_idle_zero_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != RUN_DRIVE |-> out_left_r == '0 && out_right_r == '0)
    else $error("nonzero wheel power outside a driving run");

  a_power_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_left_r <= FULL_POWER && out_right_r <= FULL_POWER)
    else $error("wheel power above full scale");

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    integ_r <= INT_LIM && integ_r >= -INT_LIM)
    else $error("error integral outside its limit");

  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_restart_r && phase_r != RUN_DRIVE |=> phase_r == $past(phase_r))
    else $error("run phase left a stopped state without restart");

  a_no_state_move: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(phase_r) && $stable(integ_r) && $stable(cur_err_r))
    else $error("controller state changed without a transaction");
`endif

endmodule
